### src/msp_fb_pkg.sv
`timescale 1ns / 1ps
package msp_fb_pkg;

	// Frame characters
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_X      = 8'h58;
	localparam logic [7:0] CH_LT     = 8'h3C;

	// Extra bytes the v2 header and its CRC add to the v1 wrapper size
	localparam logic [7:0] TUN_SIZE_EXTRA = 8'd6;

	// Configuration register map
	localparam int unsigned ADDR_W       = 3;
	localparam logic        REG_TUNNEL_CMD = 1'b0;
	localparam logic [7:0]  TUNNEL_CMD_RESET = 8'hFF;

	// Depth of the queue between front and back
	localparam int unsigned QUEUE_DEPTH = 4;

	typedef enum logic [1:0] {
		MODE_V1  = 2'd0,
		MODE_V2  = 2'd1,
		MODE_TUN = 2'd2
	} mode_t;

	typedef enum logic [3:0] {
		PH_SYNC,
		PH_PROTO,
		PH_DIR,
		PH_SIZE,
		PH_CMD1,
		PH_FLAGS,
		PH_CMDLO,
		PH_CMDHI,
		PH_LENLO,
		PH_LENHI,
		PH_PAYLOAD,
		PH_CRC,
		PH_XOR,
		PH_DONE
	} phase_t;

	// One classified item handed from front to back
	typedef struct packed {
		logic        first;
		mode_t       mode;
		logic [15:0] cmd;
		logic [7:0]  flags;
		logic [15:0] len;
		logic [7:0]  tun_cmd;
		logic [7:0]  pb;
		logic        has;
		logic        last;
	} job_t;

	// Queue handshake between front and back
	typedef struct packed {
		logic push;
		logic full;
	} qctl_t;

	// CRC-8 DVB-S2 update by one byte, polynomial 0xD5
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			c = c[7] ? ((c << 1) ^ 8'hD5) : (c << 1);
		end
		return c;
	endfunction

endpackage

### src/msp_fb_stream_if.sv
`timescale 1ns / 1ps
interface msp_fb_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  frame_mode;
	logic [15:0] command;
	logic [7:0]  flags;
	logic [15:0] data_len;
	logic [7:0]  payload_byte;
	logic        has_byte;
	logic        last_byte;

	modport source(output valid, frame_mode, command, flags, data_len, payload_byte,
		has_byte, last_byte, input ready);
	modport sink(input valid, frame_mode, command, flags, data_len, payload_byte,
		has_byte, last_byte, output ready);
endinterface

interface msp_fb_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       frame_end;

	modport source(output valid, frame_byte, frame_end, input ready);
	modport sink(input valid, frame_byte, frame_end, output ready);
endinterface

### src/msp_frame_builder_core.sv
`timescale 1ns / 1ps
// MSP request framer.
// req (sink): one beat per payload item. The first beat of a frame carries
//   frame_mode, command, flags and payload_length; has_byte marks a payload
//   byte, last_byte closes the frame.
// frame (source): the serialized frame, one byte per beat, frame_end on the
//   final checksum or CRC byte.
// APB port: register 0 (byte address 0) is tunnel_command, the v1 command of
//   the v2-over-v1 wrapper; reset value 0xFF. pready is tied high.
// Path: queue, current-item register, output register, in that order.
// Throughput: the output runs at one byte per cycle while frame.ready is high,
//   set by the single serializer in the back end. A payload beat adds one frame
//   byte, a first beat up to ten (header), a closing beat one or two more
//   (trailer). A 4-entry queue sits between the front end and the serializer, so
//   input beats keep flowing while a header or trailer is being sent.
// Stall: when frame.ready is low the output byte holds, the serializer
//   pauses, and req.ready drops once the queue is full.
// Reset: arst_n clears the queue, the frame tracking and the output valid;
//   the block then waits for the first beat of a new frame.
module msp_frame_builder_core #(
	parameter int unsigned QueueDepth = msp_fb_pkg::QUEUE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [msp_fb_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	msp_fb_in_if.sink                     req,
	msp_fb_out_if.source                  frame
);

	logic [7:0]        tunnel_cmd_q;
	msp_fb_pkg::qctl_t qctl;
	msp_fb_pkg::job_t  push_job;
	msp_fb_pkg::job_t  pop_job;
	logic              q_full;
	logic              q_valid;
	logic              q_pop;

	// configuration register
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tunnel_cmd_q <= msp_fb_pkg::TUNNEL_CMD_RESET;
		end else if (psel && penable && pwrite && pready
				&& paddr[2] == msp_fb_pkg::REG_TUNNEL_CMD) begin
			tunnel_cmd_q <= pwdata[7:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == msp_fb_pkg::REG_TUNNEL_CMD) begin
			prdata = {24'b0, tunnel_cmd_q};
		end
	end

	msp_fb_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req),
		.tunnel_command (tunnel_cmd_q),
		.qctl_push      (qctl),
		.q_full         (q_full),
		.push_job       (push_job)
	);

	msp_fb_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.qctl_push (qctl),
		.push_job  (push_job),
		.full      (q_full),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_job   (pop_job)
	);

	msp_fb_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_job   (pop_job),
		.pop     (q_pop),
		.frame   (frame)
	);

endmodule

### src/msp_fb_front.sv
`timescale 1ns / 1ps
module msp_fb_front (
	input  logic                clk,
	input  logic                arst_n,
	msp_fb_in_if.sink           req,
	input  logic [7:0]          tunnel_command,
	output msp_fb_pkg::qctl_t   qctl_push,
	input  logic                q_full,
	output msp_fb_pkg::job_t    push_job
);

	logic              in_frame_q;
	msp_fb_pkg::mode_t mode_q;
	msp_fb_pkg::mode_t raw_mode;
	logic              accept;

	// take a beat whenever the queue has room
	assign req.ready = !q_full;
	assign accept    = req.valid && req.ready;

	// decode the requested mode, reserved code falls back to v1
	always_comb begin
		unique case (req.frame_mode)
			msp_fb_pkg::MODE_V2:  raw_mode = msp_fb_pkg::MODE_V2;
			msp_fb_pkg::MODE_TUN: raw_mode = msp_fb_pkg::MODE_TUN;
			default:              raw_mode = msp_fb_pkg::MODE_V1;
		endcase
	end

	// classify the beat: header fields only count on the first item
	always_comb begin
		push_job.first   = !in_frame_q;
		push_job.mode    = in_frame_q ? mode_q : raw_mode;
		push_job.cmd     = req.command;
		push_job.flags   = req.flags;
		push_job.len     = req.data_len;
		push_job.tun_cmd = tunnel_command;
		push_job.pb      = req.payload_byte;
		push_job.has     = req.has_byte;
		push_job.last    = req.last_byte;
		qctl_push.push   = accept;
		qctl_push.full   = q_full;
	end

	// track frame boundaries and hold the mode for the rest of the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			mode_q     <= msp_fb_pkg::MODE_V1;
		end else if (accept) begin
			in_frame_q <= !req.last_byte;
			if (!in_frame_q) begin
				mode_q <= raw_mode;
			end
		end
	end

endmodule

### src/msp_fb_queue.sv
`timescale 1ns / 1ps
module msp_fb_queue #(
	parameter int unsigned Depth = msp_fb_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  msp_fb_pkg::qctl_t qctl_push,
	input  msp_fb_pkg::job_t  push_job,
	output logic              full,
	input  logic              pop,
	output logic              pop_valid,
	output msp_fb_pkg::job_t  pop_job
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	msp_fb_pkg::job_t mem_q [Depth];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == CntW'(Depth));
	assign pop_valid = (count_q != '0);
	assign pop_job   = mem_q[rd_ptr_q];
	assign do_push   = qctl_push.push && !full;
	assign do_pop    = pop && pop_valid;

	// store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### src/msp_fb_back.sv
`timescale 1ns / 1ps
module msp_fb_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  msp_fb_pkg::job_t  q_job,
	output logic              pop,
	msp_fb_out_if.source      frame
);

	msp_fb_pkg::job_t   cur_job_q;
	msp_fb_pkg::phase_t cur_phase_q;
	msp_fb_pkg::phase_t phase_d;
	msp_fb_pkg::phase_t nxt;
	msp_fb_pkg::phase_t start_ph;
	logic               cur_valid_q;
	logic               valid_d;
	logic               advance;
	logic [7:0]         xor_q;
	logic [7:0]         crc_q;
	logic [7:0]         byte_d;
	logic               end_d;
	logic               out_valid_q;
	logic [7:0]         out_byte_q;
	logic               out_end_q;

	function automatic msp_fb_pkg::phase_t trailer_ph(input msp_fb_pkg::job_t j);
		return (j.mode == msp_fb_pkg::MODE_V1) ? msp_fb_pkg::PH_XOR : msp_fb_pkg::PH_CRC;
	endfunction

	function automatic msp_fb_pkg::phase_t body_ph(input msp_fb_pkg::job_t j);
		msp_fb_pkg::phase_t p;
		if (j.has) begin
			p = msp_fb_pkg::PH_PAYLOAD;
		end else if (j.last) begin
			p = trailer_ph(j);
		end else begin
			p = msp_fb_pkg::PH_DONE;
		end
		return p;
	endfunction

	function automatic msp_fb_pkg::phase_t next_ph(input msp_fb_pkg::phase_t p,
			input msp_fb_pkg::job_t j);
		msp_fb_pkg::phase_t n;
		unique case (p)
			msp_fb_pkg::PH_SYNC:  n = msp_fb_pkg::PH_PROTO;
			msp_fb_pkg::PH_PROTO: n = msp_fb_pkg::PH_DIR;
			msp_fb_pkg::PH_DIR: begin
				n = (j.mode == msp_fb_pkg::MODE_V2) ? msp_fb_pkg::PH_FLAGS : msp_fb_pkg::PH_SIZE;
			end
			msp_fb_pkg::PH_SIZE:  n = msp_fb_pkg::PH_CMD1;
			msp_fb_pkg::PH_CMD1: begin
				n = (j.mode == msp_fb_pkg::MODE_TUN) ? msp_fb_pkg::PH_FLAGS : body_ph(j);
			end
			msp_fb_pkg::PH_FLAGS: n = msp_fb_pkg::PH_CMDLO;
			msp_fb_pkg::PH_CMDLO: n = msp_fb_pkg::PH_CMDHI;
			msp_fb_pkg::PH_CMDHI: n = msp_fb_pkg::PH_LENLO;
			msp_fb_pkg::PH_LENLO: n = msp_fb_pkg::PH_LENHI;
			msp_fb_pkg::PH_LENHI: n = body_ph(j);
			msp_fb_pkg::PH_PAYLOAD: n = j.last ? trailer_ph(j) : msp_fb_pkg::PH_DONE;
			msp_fb_pkg::PH_CRC: begin
				n = (j.mode == msp_fb_pkg::MODE_TUN) ? msp_fb_pkg::PH_XOR : msp_fb_pkg::PH_DONE;
			end
			default: n = msp_fb_pkg::PH_DONE;
		endcase
		return n;
	endfunction

	// move a byte whenever the output register is free or being drained
	assign advance  = cur_valid_q && (!out_valid_q || frame.ready);
	assign nxt      = next_ph(cur_phase_q, cur_job_q);
	assign start_ph = q_job.first ? msp_fb_pkg::PH_SYNC : body_ph(q_job);
	assign pop      = q_valid && (!cur_valid_q || (advance && nxt == msp_fb_pkg::PH_DONE));

	// next phase: load a fresh item or step through the current one
	always_comb begin
		phase_d = cur_phase_q;
		valid_d = cur_valid_q;
		if (pop) begin
			phase_d = start_ph;
			valid_d = (start_ph != msp_fb_pkg::PH_DONE);
		end else if (advance) begin
			phase_d = nxt;
			valid_d = (nxt != msp_fb_pkg::PH_DONE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_phase_q <= msp_fb_pkg::PH_DONE;
			cur_valid_q <= 1'b0;
		end else begin
			cur_phase_q <= phase_d;
			cur_valid_q <= valid_d;
		end
	end

	// hold the item being serialized
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_job_q <= q_job;
		end
	end

	// select the frame byte for the current phase
	always_comb begin
		end_d = 1'b0;
		unique case (cur_phase_q)
			msp_fb_pkg::PH_SYNC:  byte_d = msp_fb_pkg::CH_DOLLAR;
			msp_fb_pkg::PH_PROTO: begin
				byte_d = (cur_job_q.mode == msp_fb_pkg::MODE_V2) ? msp_fb_pkg::CH_X
					: msp_fb_pkg::CH_M;
			end
			msp_fb_pkg::PH_DIR:   byte_d = msp_fb_pkg::CH_LT;
			msp_fb_pkg::PH_SIZE: begin
				byte_d = (cur_job_q.mode == msp_fb_pkg::MODE_TUN)
					? cur_job_q.len[7:0] + msp_fb_pkg::TUN_SIZE_EXTRA : cur_job_q.len[7:0];
			end
			msp_fb_pkg::PH_CMD1: begin
				byte_d = (cur_job_q.mode == msp_fb_pkg::MODE_TUN) ? cur_job_q.tun_cmd
					: cur_job_q.cmd[7:0];
			end
			msp_fb_pkg::PH_FLAGS:   byte_d = cur_job_q.flags;
			msp_fb_pkg::PH_CMDLO:   byte_d = cur_job_q.cmd[7:0];
			msp_fb_pkg::PH_CMDHI:   byte_d = cur_job_q.cmd[15:8];
			msp_fb_pkg::PH_LENLO:   byte_d = cur_job_q.len[7:0];
			msp_fb_pkg::PH_LENHI:   byte_d = cur_job_q.len[15:8];
			msp_fb_pkg::PH_PAYLOAD: byte_d = cur_job_q.pb;
			msp_fb_pkg::PH_CRC: begin
				byte_d = crc_q;
				end_d  = (cur_job_q.mode == msp_fb_pkg::MODE_V2);
			end
			msp_fb_pkg::PH_XOR: begin
				byte_d = xor_q;
				end_d  = 1'b1;
			end
			default: byte_d = '0;
		endcase
	end

	// fold the bytes from size or flags through CRC into the checksums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xor_q <= '0;
			crc_q <= '0;
		end else if (advance) begin
			case (cur_phase_q)
				msp_fb_pkg::PH_SYNC: begin
					xor_q <= '0;
					crc_q <= '0;
				end
				msp_fb_pkg::PH_SIZE, msp_fb_pkg::PH_CMD1, msp_fb_pkg::PH_CRC: begin
					xor_q <= xor_q ^ byte_d;
				end
				msp_fb_pkg::PH_FLAGS, msp_fb_pkg::PH_CMDLO, msp_fb_pkg::PH_CMDHI,
				msp_fb_pkg::PH_LENLO, msp_fb_pkg::PH_LENHI, msp_fb_pkg::PH_PAYLOAD: begin
					xor_q <= xor_q ^ byte_d;
					crc_q <= msp_fb_pkg::crc8_step(crc_q, byte_d);
				end
				default: begin
					xor_q <= xor_q;
				end
			endcase
		end
	end

	// output register: load on advance, drop when the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (frame.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte_q <= byte_d;
			out_end_q  <= end_d;
		end
	end

	assign frame.valid      = out_valid_q;
	assign frame.frame_byte = out_byte_q;
	assign frame.frame_end  = out_end_q;

endmodule

### src/msp_fb_checker.sv
`timescale 1ns / 1ps
module msp_fb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       out_end
);

	logic start_q;
	logic proto_q;
	logic beat;

	assign beat = out_valid && out_ready;

	// track where the next output beat sits in the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b1;
			proto_q <= 1'b0;
		end else if (beat) begin
			start_q <= out_end;
			proto_q <= start_q;
		end
	end

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("frame valid dropped while stalled");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_byte) && $stable(out_end))
		else $error("frame beat changed while stalled");

	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && start_q |-> out_byte == msp_fb_pkg::CH_DOLLAR && !out_end)
		else $error("frame does not open with sync byte");

	a_frame_proto: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && proto_q |-> (out_byte == msp_fb_pkg::CH_M || out_byte == msp_fb_pkg::CH_X))
		else $error("protocol byte is neither M nor X");

endmodule

bind msp_frame_builder_core msp_fb_checker u_msp_fb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (frame.valid),
	.out_ready (frame.ready),
	.out_byte  (frame.frame_byte),
	.out_end   (frame.frame_end)
);

### verif/msp_fb_frame_checker.sv
`timescale 1ns / 1ps
module msp_fb_frame_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic                          pready,
	input  logic [msp_fb_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                   pwdata,
	input  logic                          req_valid,
	input  logic                          req_ready,
	input  logic [1:0]                    req_mode,
	input  logic [15:0]                   req_command,
	input  logic [7:0]                    req_flags,
	input  logic [15:0]                   req_length,
	input  logic [7:0]                    req_byte,
	input  logic                          req_has,
	input  logic                          req_last,
	input  logic                          frm_valid,
	input  logic                          frm_ready,
	input  logic [7:0]                    frm_byte,
	input  logic                          frm_end,
	output int                            mismatches,
	output int                            bytes_due,
	output int                            bytes_seen
);
	import msp_fb_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       fin;
	} fbyte_t;

	// Frame bytes still owed by the block, oldest first
	fbyte_t due_q[$];
	fbyte_t head;

	// Shadow of the framer state and the tunnel register
	logic       open;
	mode_t      cur_mode;
	logic [7:0] xsum;
	logic [7:0] crc;
	logic [7:0] tun_cmd;

	// CRC-8 DVB-S2, shifted in one bit at a time, MSB first
	function automatic logic [7:0] crc_dvb(input logic [7:0] acc, input logic [7:0] b);
		logic [7:0] r;
		logic       fb;
		r = acc;
		for (int i = 7; i >= 0; i--) begin
			fb = r[7] ^ b[i];
			r = {r[6:0], 1'b0} ^ (fb ? 8'hD5 : 8'h00);
		end
		return r;
	endfunction

	task put(input logic [7:0] d, input logic f);
		fbyte_t e;
		e.data = d;
		e.fin = f;
		due_q.insert(due_q.size(), e);
	endtask

	// Body bytes feed both the XOR and the CRC
	task put_body(input logic [7:0] d);
		put(d, 1'b0);
		xsum = xsum ^ d;
		crc = crc_dvb(crc, d);
	endtask

	task put_v2_header(input logic [7:0] fl, input logic [15:0] cmd, input logic [15:0] len);
		put_body(fl);
		put_body(cmd[7:0]);
		put_body(cmd[15:8]);
		put_body(len[7:0]);
		put_body(len[15:8]);
	endtask

	// Work out the frame bytes one request beat causes
	task predict_frame_bytes(input logic [1:0] mode, input logic [15:0] cmd,
			input logic [7:0] fl, input logic [15:0] len, input logic [7:0] pb,
			input logic has, input logic last);
		logic [7:0] sz;
		if (!open) begin
			if (mode == MODE_V2)
				cur_mode = MODE_V2;
			else if (mode == MODE_TUN)
				cur_mode = MODE_TUN;
			else
				cur_mode = MODE_V1;
			xsum = 8'h00;
			crc = 8'h00;
			put(CH_DOLLAR, 1'b0);
			case (cur_mode)
				MODE_V2: begin
					put(CH_X, 1'b0);
					put(CH_LT, 1'b0);
					put_v2_header(fl, cmd, len);
				end
				MODE_TUN: begin
					put(CH_M, 1'b0);
					put(CH_LT, 1'b0);
					sz = len[7:0] + TUN_SIZE_EXTRA;
					put(sz, 1'b0);
					put(tun_cmd, 1'b0);
					xsum = sz ^ tun_cmd;
					put_v2_header(fl, cmd, len);
				end
				default: begin
					put(CH_M, 1'b0);
					put(CH_LT, 1'b0);
					sz = len[7:0];
					put(sz, 1'b0);
					put(cmd[7:0], 1'b0);
					xsum = sz ^ cmd[7:0];
				end
			endcase
			open = 1'b1;
		end
		if (has)
			put_body(pb);
		if (last) begin
			case (cur_mode)
				MODE_V2: put(crc, 1'b1);
				MODE_TUN: begin
					put(crc, 1'b0);
					xsum = xsum ^ crc;
					put(xsum, 1'b1);
				end
				default: put(xsum, 1'b1);
			endcase
			open = 1'b0;
		end
	endtask

	// Track the register, predict on request beats, compare frame beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			due_q.delete();
			open = 1'b0;
			cur_mode = MODE_V1;
			xsum = 8'h00;
			crc = 8'h00;
			tun_cmd = TUNNEL_CMD_RESET;
			mismatches = 0;
			bytes_seen = 0;
			bytes_due = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[2] == REG_TUNNEL_CMD)
				tun_cmd = pwdata[7:0];
			if (req_valid && req_ready)
				predict_frame_bytes(req_mode, req_command, req_flags, req_length, req_byte,
					req_has, req_last);
			if (frm_valid && frm_ready) begin
				bytes_seen++;
				if (due_q.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected frame beat: byte %02h end %0b", $time,
						frm_byte, frm_end);
				end else begin
					head = due_q.pop_front();
					if (head.data !== frm_byte || head.fin !== frm_end) begin
						mismatches++;
						$display("%0t: beat %0d: expected %02h end %0b, got %02h end %0b",
							$time, bytes_seen, head.data, head.fin, frm_byte, frm_end);
					end
				end
			end
			bytes_due = due_q.size();
		end
	end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
module tb;
	import msp_fb_pkg::*;

	localparam int N_ITEMS = 410;
	localparam int N_PHASES = 5;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;

	int mismatches;
	int bytes_due;
	int bytes_seen;
	int beats_sent;
	int frames_sent;
	int settings;
	int snk_hold;
	bit src_calm;
	bit snk_calm;

	msp_fb_in_if  req_if ();
	msp_fb_out_if frm_if ();

	always #6 clk = ~clk;

	msp_frame_builder_core u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_if),
		.frame   (frm_if)
	);

	msp_fb_frame_checker u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.req_valid   (req_if.valid),
		.req_ready   (req_if.ready),
		.req_mode    (req_if.frame_mode),
		.req_command (req_if.command),
		.req_flags   (req_if.flags),
		.req_length  (req_if.data_len),
		.req_byte    (req_if.payload_byte),
		.req_has     (req_if.has_byte),
		.req_last    (req_if.last_byte),
		.frm_valid   (frm_if.valid),
		.frm_ready   (frm_if.ready),
		.frm_byte    (frm_if.frame_byte),
		.frm_end     (frm_if.frame_end),
		.mismatches  (mismatches),
		.bytes_due   (bytes_due),
		.bytes_seen  (bytes_seen)
	);

	// Mostly no gap, often a short one, now and then a long one
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Present one request beat after an optional gap, hold until taken
	task automatic send_beat(input logic [1:0] mode, input logic [15:0] cmd,
			input logic [7:0] fl, input logic [15:0] len, input logic [7:0] pb,
			input logic has, input logic last);
		int g;
		g = src_calm ? 0 : idle_len();
		if (g > 0) begin
			req_if.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.frame_mode <= mode;
		req_if.command <= cmd;
		req_if.flags <= fl;
		req_if.data_len <= len;
		req_if.payload_byte <= pb;
		req_if.has_byte <= has;
		req_if.last_byte <= last;
		do @(posedge clk); while (req_if.ready !== 1'b1);
		beats_sent++;
		if (last)
			frames_sent++;
	endtask

	// Later beats of a frame carry junk header fields, which must be ignored
	task automatic send_more(input logic [7:0] pb, input logic has, input logic last);
		send_beat(2'($urandom), 16'($urandom), 8'($urandom), 16'($urandom), pb, has, last);
	endtask

	// Build one frame with random shape and content
	task automatic send_random_frame();
		logic        has_q[$];
		logic [1:0]  mode;
		logic [15:0] cmd;
		logic [15:0] len;
		int          nbytes;
		int          r;
		int          noise;
		if ($urandom_range(0, 9) == 0)
			src_calm = !src_calm;
		r = $urandom_range(0, 9);
		mode = (r < 3) ? MODE_V1 : (r < 6) ? MODE_V2 : (r < 9) ? MODE_TUN : 2'd3;
		r = $urandom_range(0, 7);
		cmd = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom);
		nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
		r = $urandom_range(0, 9);
		if (r < 6)
			len = 16'(nbytes);
		else if (r < 8)
			len = 16'($urandom);
		else
			len = 16'($urandom_range(16'hFFF9, 16'hFFFF));
		noise = ($urandom_range(0, 3) == 0) ? 20 : 0;
		// Lay out has_byte per beat; the final beat closes the frame
		if ($urandom_range(0, 7) == 0)
			has_q.insert(has_q.size(), 1'b0);
		for (int i = 0; i < nbytes; i++) begin
			has_q.insert(has_q.size(), 1'b1);
			if ($urandom_range(0, 99) < noise)
				has_q.insert(has_q.size(), 1'b0);
		end
		if (has_q.size() == 0 || $urandom_range(0, 5) == 0)
			has_q.insert(has_q.size(), 1'b0);
		for (int i = 0; i < has_q.size(); i++) begin
			if (i == 0)
				send_beat(mode, cmd, 8'($urandom), len, 8'($urandom), has_q[i],
					i == has_q.size() - 1);
			else
				send_more(8'($urandom), has_q[i], i == has_q.size() - 1);
		end
	endtask

	// Drain the block, then write the tunnel command over the config port
	task automatic write_tunnel(input logic [7:0] val);
		logic [ADDR_W-1:0] a;
		logic [31:0]       w;
		a = {REG_TUNNEL_CMD, 2'b00};
		w = $urandom;
		w[7:0] = val;
		req_if.valid <= 1'b0;
		@(posedge clk);
		wait (bytes_due == 0);
		repeat (12) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= a;
		pwdata <= w;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		settings++;
	endtask

	// Frame sink: random stalls with quiet stretches
	initial begin
		frm_if.ready <= 1'b0;
		snk_hold = 0;
		snk_calm = 1'b0;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 199) == 0)
				snk_calm = !snk_calm;
			if (snk_hold > 0) begin
				frm_if.ready <= 1'b0;
				snk_hold--;
			end else begin
				frm_if.ready <= 1'b1;
				if (!snk_calm && $urandom_range(0, 2) == 0)
					snk_hold = idle_len();
			end
		end
	end

	// Stimulus and verdict
	initial begin : stim
		int         base;
		logic [7:0] tv;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		req_if.valid <= 1'b0;
		req_if.frame_mode <= '0;
		req_if.command <= '0;
		req_if.flags <= '0;
		req_if.data_len <= '0;
		req_if.payload_byte <= '0;
		req_if.has_byte <= 1'b0;
		req_if.last_byte <= 1'b0;
		src_calm = 1'b0;
		beats_sent = 0;
		frames_sent = 0;
		settings = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty frames in each mode; tunnel size wraps to zero
		send_beat(MODE_V1, 16'h0000, 8'h00, 16'h0000, 8'h00, 1'b0, 1'b1);
		send_beat(MODE_V2, 16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF, 1'b0, 1'b1);
		send_beat(MODE_TUN, 16'h1234, 8'hA5, 16'hFFFA, 8'h00, 1'b0, 1'b1);
		// Mode three acts as v1, flags ignored
		send_beat(2'd3, 16'hABFF, 8'hFF, 16'h0001, 8'hFF, 1'b1, 1'b1);
		// Header-only opener, byteless beat mid-frame, trailer on its own beat
		send_beat(MODE_V1, 16'h00C8, 8'h3C, 16'h0002, 8'h77, 1'b0, 1'b0);
		send_more(8'h00, 1'b1, 1'b0);
		send_more(8'hFF, 1'b1, 1'b0);
		send_more(8'h5A, 1'b0, 1'b0);
		send_more(8'hA5, 1'b0, 1'b1);
		// Declared length disagrees with the bytes sent, except in the last tunnel frame
		send_beat(MODE_V2, 16'h8001, 8'h00, 16'h0100, 8'h80, 1'b1, 1'b0);
		send_more(8'h01, 1'b1, 1'b1);
		send_beat(MODE_TUN, 16'hFFFF, 8'hFF, 16'h00FA, 8'h55, 1'b1, 1'b0);
		send_more(8'hAA, 1'b1, 1'b0);
		send_more(8'h00, 1'b1, 1'b1);
		send_beat(MODE_V2, 16'h0000, 8'h00, 16'h0000, 8'hFF, 1'b1, 1'b1);
		send_beat(MODE_TUN, 16'h0000, 8'h00, 16'h0000, 8'h00, 1'b0, 1'b0);
		send_more(8'h00, 1'b0, 1'b1);

		// Random frames, one tunnel setting per phase
		base = beats_sent;
		for (int p = 0; p < N_PHASES; p++) begin
			case (p)
				0: tv = 8'h00;
				1: tv = 8'hFF;
				3: tv = 8'h01;
				default: tv = 8'($urandom);
			endcase
			write_tunnel(tv);
			while (beats_sent < base + (p + 1) * (N_ITEMS / N_PHASES))
				send_random_frame();
		end

		// Drain and let any stray bytes show up
		req_if.valid <= 1'b0;
		@(posedge clk);
		wait (bytes_due == 0);
		repeat (20) @(posedge clk);

		$display("sent %0d request beats in %0d frames over v1, v2 and tunneled modes",
			beats_sent, frames_sent);
		$display("checked %0d frame bytes across %0d tunnel command settings",
			bytes_seen, settings + 1);
		if (mismatches == 0 && bytes_due == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Watchdog
	initial begin
		#20000000;
		$display("timeout with %0d frame bytes still due", bytes_due);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
